// ----- rtl/rpa_pkg.sv -----
// ============================================================================
// rpa_pkg
// Shared types, codes and constants of the relay PID autotuner.
// ============================================================================
`default_nettype none

package rpa_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int WINDOW_DEPTH = 256;
    localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
    localparam int MAX_PEAKS    = 64;
    localparam int PEAK_AW      = $clog2(MAX_PEAKS);

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ABORT  = 2'd2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TUNING = 2'd1;
    localparam logic [1:0] ST_STABLE = 2'd2;
    localparam logic [1:0] ST_UNRES  = 2'd3;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_BAND   = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_CYCLES = 3'd3;
    localparam logic [2:0] REG_WINDOW = 3'd4;

    localparam logic [6:0]  MIN_CYCLES = 7'd8;
    localparam logic [6:0]  MAX_CYC    = 7'd64;
    localparam logic [8:0]  MAX_WIN    = 9'd256;
    localparam logic [31:0] TICK_MS    = 32'd50;
    localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

    localparam logic [22:0] K_GP = 23'd7680000;
    localparam logic [33:0] K_GI = 34'd15360000000;
    localparam logic [9:0]  K_GD = 10'd960;
    localparam logic [18:0] K_PI = 19'd314159;
    localparam logic [67:0] GI_LIMIT = 68'h0_4000_0000_0000_0000;

    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 63;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_SAMPLE,
        CMD_ABORT,
        CMD_NOP
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic signed [15:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [15:0] target_temp;
        logic [11:0]        noise_band;
        logic [7:0]         drive_step;
        logic [6:0]         max_cycles;
        logic [8:0]         window_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  heater_drive;
        logic [1:0]  status;
        logic [6:0]  peak_count;
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
    } result_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_SCAN,
        B_PEAK,
        B_PK1,
        B_PK2,
        B_PK3,
        B_PK4,
        B_CHK,
        B_FIN,
        B_MUL1,
        B_MUL2,
        B_MUL3,
        B_MUL4,
        B_DIVP,
        B_WAITP,
        B_DIVI,
        B_WAITI,
        B_DIVD,
        B_WAITD,
        B_DONE,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/relay_pid_autotuner_unit.sv -----
// ============================================================================
// relay_pid_autotuner_unit
// Relay-feedback PID autotuner with Ziegler-Nichols gain solve.
// ============================================================================
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+-----------------------------------
//  s_       | in        | tvalid / tready   | tuser kind, tdata sample
//  m_       | out       | tvalid / tready   | tuser status, tdata drive/count/gains
//  cfg_     | in        | cfg_we            | cfg_addr index, cfg_wdata value
//
//  Start, abort and idle samples go from dispatch straight to the result.
//  Window samples scan the history window, one history memory read per cycle.
//  A peak check may follow; the gain solve runs up to three 68-step divides.
//  Two requests queue ahead of the engine; one result waits in the output register.
//  Reset: asynchronous, active low; configuration returns to its defaults.
// ============================================================================
`default_nettype none

module relay_pid_autotuner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [111:0] m_tdata,  // [7:0] heater_drive, [14:8] peak_count,
                                   // [46:15] gain_p, [78:47] gain_i, [110:79] gain_d
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import rpa_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET: cfg_next.target_temp = cfg_wdata;
                REG_BAND:   cfg_next.noise_band  = cfg_wdata[11:0];
                REG_STEP:   cfg_next.drive_step  = cfg_wdata[7:0];
                REG_CYCLES: cfg_next.max_cycles  = cfg_wdata[6:0];
                REG_WINDOW: cfg_next.window_len  = cfg_wdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp <= 16'sd2400;
            cfg_reg.noise_band  <= 12'd8;
            cfg_reg.drive_step  <= 8'd255;
            cfg_reg.max_cycles  <= 7'd8;
            cfg_reg.window_len  <= 9'd200;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res.gain_d, res.gain_i, res.gain_p,
                      res.peak_count, res.heater_drive};
    assign m_tuser = res.status;

endmodule

`default_nettype wire

// ----- rtl/rpa_front.sv -----
// ============================================================================
// rpa_front
// Input side: decode the request kind and hold requests in a two-entry queue.
// ============================================================================
`default_nettype none

module rpa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              q_valid,
    output rpa_pkg::item_t    q_item,
    input  logic              q_pop
);
    import rpa_pkg::*;

    item_t      fifo_mem [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    item_t      in_item;

    always_comb
    begin
        case (s_tuser)
            KIND_START:  in_item.cmd = CMD_START;
            KIND_SAMPLE: in_item.cmd = CMD_SAMPLE;
            KIND_ABORT:  in_item.cmd = CMD_ABORT;
            default:     in_item.cmd = CMD_NOP;
        endcase
        in_item.sample = s_tdata;
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rpa_div.sv -----
// ============================================================================
// rpa_div
// Bit-serial Q16.16 divider: round half up, saturate to all ones.
// ============================================================================
`default_nettype none

module rpa_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [rpa_pkg::DIV_NUM_W-1:0]      num,
    input  logic [rpa_pkg::DIV_DEN_W-1:0]      den,
    output logic                               done,
    output logic [31:0]                        quot
);
    import rpa_pkg::*;

    localparam int NW = DIV_NUM_W + 18;
    localparam int DW = DIV_DEN_W + 1;

    logic          run_reg;
    logic          run_next;
    logic          done_reg;
    logic          done_next;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] n_next;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] d_next;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] r_next;
    logic [6:0]    cnt_reg;
    logic [6:0]    cnt_next;
    logic [31:0]   q_reg;
    logic [31:0]   q_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [DW:0]   shifted;
    logic          ge;

    assign shifted = {r_reg, n_reg[NW-1]};
    assign ge      = (shifted >= {1'b0, d_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            q_next = 32'd0;
            if (den == '0)
            begin
                ovf_next  = (num != '0);
                done_next = 1'b1;
                run_next  = 1'b0;
            end
            else
            begin
                n_next   = {1'b0, num, 17'd0} + {5'd0, den};
                d_next   = {den, 1'b0};
                r_next   = '0;
                cnt_next = 7'(NW);
                ovf_next = 1'b0;
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            r_next   = ge ? DW'(shifted - {1'b0, d_reg}) : shifted[DW-1:0];
            n_next   = {n_reg[NW-2:0], 1'b0};
            q_next   = {q_reg[30:0], ge};
            ovf_next = ovf_reg | q_reg[31];
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            ovf_reg  <= 1'b0;
            q_reg    <= 32'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            q_reg    <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign quot = ovf_reg ? SAT32 : q_reg;

endmodule

`default_nettype wire

// ----- rtl/rpa_back.sv -----
// ============================================================================
// rpa_back
// Tuning engine: relay control, window scan, peak tracking and gain solve.
// ============================================================================
`default_nettype none

module rpa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rpa_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  rpa_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output rpa_pkg::result_t  res
);
    import rpa_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;

    logic [8:0]         fill_reg;
    logic [8:0]         fill_next;
    logic [HIST_AW-1:0] wp_reg;
    logic [HIST_AW-1:0] wp_next;
    logic [6:0]         pidx_reg;
    logic [6:0]         pidx_next;
    logic [1:0]         pdir_reg;
    logic [1:0]         pdir_next;
    logic               seen_reg;
    logic               seen_next;
    logic signed [15:0] amax_reg;
    logic signed [15:0] amax_next;
    logic signed [15:0] amin_reg;
    logic signed [15:0] amin_next;
    logic [31:0]        tick_reg;
    logic [31:0]        tick_next;
    logic [31:0]        lmax_reg;
    logic [31:0]        lmax_next;
    logic [31:0]        pmax_reg;
    logic [31:0]        pmax_next;
    logic [7:0]         drive_reg;
    logic [7:0]         drive_next;
    logic               active_reg;
    logic               active_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [31:0]        gp_reg;
    logic [31:0]        gp_next;
    logic [31:0]        gi_reg;
    logic [31:0]        gi_next;
    logic [31:0]        gd_reg;
    logic [31:0]        gd_next;
    logic [1:0]         code_reg;
    logic [1:0]         code_next;
    logic [8:0]         cnt_reg;
    logic [8:0]         cnt_next;
    logic               rdp_reg;
    logic               rdp_next;
    logic               ismax_reg;
    logic               ismax_next;
    logic               ismin_reg;
    logic               ismin_next;
    logic               res_valid_reg;
    logic               res_valid_next;

    logic signed [15:0] samp_reg;
    logic signed [15:0] samp_next;
    logic signed [15:0] p1_reg;
    logic signed [15:0] p1_next;
    logic signed [15:0] p2_reg;
    logic signed [15:0] p2_next;
    logic signed [15:0] p3_reg;
    logic signed [15:0] p3_next;
    logic [35:0]        d1_reg;
    logic [35:0]        d1_next;
    logic [31:0]        per_reg;
    logic [31:0]        per_next;
    logic [17:0]        sd_reg;
    logic [17:0]        sd_next;
    logic [49:0]        lo_reg;
    logic [49:0]        lo_next;
    logic [49:0]        hi_reg;
    logic [49:0]        hi_next;
    logic [49:0]        numd_reg;
    logic [49:0]        numd_next;
    logic [67:0]        dp_reg;
    logic [67:0]        dp_next;
    result_t            res_reg;
    result_t            res_next;

    logic signed [15:0] hist_mem [0:WINDOW_DEPTH-1];
    logic signed [15:0] hist_rd;
    logic               hist_we;
    logic signed [15:0] hist_wd;
    logic [HIST_AW-1:0] hist_ra;

    logic signed [15:0] peak_mem [0:MAX_PEAKS-1];
    logic signed [15:0] peak_rd;
    logic               pk_we;
    logic [PEAK_AW-1:0] pk_wa;
    logic [PEAK_AW-1:0] pk_ra;

    logic               div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic               div_done;
    logic [31:0]        div_quot;

    logic [6:0]         cyc_eff;
    logic [8:0]         wl_eff;
    logic signed [17:0] lo_band;
    logic signed [17:0] hi_band;
    logic signed [17:0] t_in;
    logic               over;
    logic               under;
    logic               seen_new;
    logic               at_limit;
    logic               fill_short;
    logic               scan_issue;
    logic               pk_jc;
    logic [6:0]         pk_pidx;
    logic [16:0]        amp;
    logic signed [16:0] dif1;
    logic signed [16:0] dif2;
    logic [16:0]        abs1;
    logic [16:0]        abs2;
    logic [21:0]        ten_sum;
    logic               stable;
    logic [30:0]        num_p;
    logic [41:0]        num_i;

    rpa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (cfg.max_cycles < MIN_CYCLES)
        begin
            cyc_eff = MIN_CYCLES;
        end
        else if (cfg.max_cycles > MAX_CYC)
        begin
            cyc_eff = MAX_CYC;
        end
        else
        begin
            cyc_eff = cfg.max_cycles;
        end
        if (cfg.window_len == 9'd0)
        begin
            wl_eff = 9'd1;
        end
        else if (cfg.window_len > MAX_WIN)
        begin
            wl_eff = MAX_WIN;
        end
        else
        begin
            wl_eff = cfg.window_len;
        end
    end

    assign lo_band    = {{2{cfg.target_temp[15]}}, cfg.target_temp} - {6'd0, cfg.noise_band};
    assign hi_band    = {{2{cfg.target_temp[15]}}, cfg.target_temp} + {6'd0, cfg.noise_band};
    assign t_in       = {{2{q_item.sample[15]}}, q_item.sample};
    assign over       = (t_in > hi_band);
    assign under      = (t_in < lo_band);
    assign seen_new   = seen_reg || over;
    assign at_limit   = (pidx_reg >= cyc_eff);
    assign fill_short = (fill_reg < wl_eff);
    assign scan_issue = (cnt_reg < wl_eff);

    always_comb
    begin
        pk_jc   = 1'b0;
        pk_pidx = pidx_reg;
        if (ismax_reg)
        begin
            pk_jc = (pdir_reg == 2'd2);
        end
        else if (ismin_reg)
        begin
            if (pdir_reg == 2'd1)
            begin
                pk_jc   = 1'b1;
                pk_pidx = pidx_reg + 7'd1;
            end
        end
    end

    assign amp     = 17'({amax_reg[15], amax_reg} - {amin_reg[15], amin_reg});
    assign dif1    = {p1_reg[15], p1_reg} - {p2_reg[15], p2_reg};
    assign dif2    = {p2_reg[15], p2_reg} - {p3_reg[15], p3_reg};
    assign abs1    = dif1[16] ? 17'(-dif1) : 17'(dif1);
    assign abs2    = dif2[16] ? 17'(-dif2) : 17'(dif2);
    assign ten_sum = 22'({5'd0, abs1} + {5'd0, abs2}) * 22'd10;
    assign stable  = (ten_sum < {5'd0, amp});
    assign num_p   = K_GP * cfg.drive_step;
    assign num_i   = K_GI * cfg.drive_step;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_OUT;
                    if (q_item.cmd == CMD_SAMPLE && active_reg)
                    begin
                        if (at_limit)
                        begin
                            state_next = B_FIN;
                        end
                        else if (seen_new && !fill_short)
                        begin
                            state_next = B_SCAN;
                        end
                    end
                end
            end
            B_SCAN:
            begin
                if (!scan_issue && !rdp_reg)
                begin
                    state_next = B_PEAK;
                end
            end
            B_PEAK:  state_next = (pk_jc && pk_pidx >= 7'd4) ? B_PK1 : B_OUT;
            B_PK1:   state_next = B_PK2;
            B_PK2:   state_next = B_PK3;
            B_PK3:   state_next = B_PK4;
            B_PK4:   state_next = B_CHK;
            B_CHK:   state_next = stable ? B_FIN : B_OUT;
            B_FIN:   state_next = B_MUL1;
            B_MUL1:  state_next = B_MUL2;
            B_MUL2:  state_next = B_MUL3;
            B_MUL3:  state_next = B_MUL4;
            B_MUL4:  state_next = B_DIVP;
            B_DIVP:  state_next = B_WAITP;
            B_WAITP: state_next = div_done ? B_DIVI : B_WAITP;
            B_DIVI:
            begin
                if (d1_reg == 36'd0 || per_reg == 32'd0 || dp_reg > GI_LIMIT)
                begin
                    state_next = B_DIVD;
                end
                else
                begin
                    state_next = B_WAITI;
                end
            end
            B_WAITI: state_next = div_done ? B_DIVD : B_WAITI;
            B_DIVD:  state_next = B_WAITD;
            B_WAITD: state_next = div_done ? B_DONE : B_WAITD;
            B_DONE:  state_next = B_OUT;
            B_OUT:   state_next = (!res_valid_reg || res_ready) ? B_IDLE : B_OUT;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        pidx_next      = pidx_reg;
        pdir_next      = pdir_reg;
        seen_next      = seen_reg;
        amax_next      = amax_reg;
        amin_next      = amin_reg;
        tick_next      = tick_reg;
        lmax_next      = lmax_reg;
        pmax_next      = pmax_reg;
        drive_next     = drive_reg;
        active_next    = active_reg;
        status_next    = status_reg;
        gp_next        = gp_reg;
        gi_next        = gi_reg;
        gd_next        = gd_reg;
        code_next      = code_reg;
        cnt_next       = cnt_reg;
        rdp_next       = 1'b0;
        ismax_next     = ismax_reg;
        ismin_next     = ismin_reg;
        res_valid_next = res_valid_reg && !res_ready;
        samp_next      = samp_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        d1_next        = d1_reg;
        per_next       = per_reg;
        sd_next        = sd_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        numd_next      = numd_reg;
        dp_next        = dp_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        hist_we        = 1'b0;
        hist_wd        = samp_reg;
        hist_ra        = HIST_AW'(wp_reg - HIST_AW'(1) - cnt_reg[HIST_AW-1:0]);
        pk_we          = 1'b0;
        pk_wa          = pidx_reg[PEAK_AW-1:0];
        pk_ra          = PEAK_AW'(pidx_reg - 7'd1);
        div_start      = 1'b0;
        div_num        = {19'd0, num_p};
        div_den        = {27'd0, d1_reg};

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    samp_next = q_item.sample;
                    case (q_item.cmd)
                        CMD_START:
                        begin
                            fill_next   = 9'd0;
                            pidx_next   = 7'd0;
                            pdir_next   = 2'd0;
                            seen_next   = 1'b0;
                            amax_next   = '0;
                            amin_next   = '0;
                            tick_next   = 32'd0;
                            lmax_next   = 32'd0;
                            pmax_next   = 32'd0;
                            drive_next  = 8'd0;
                            active_next = 1'b1;
                            status_next = ST_TUNING;
                            gp_next     = 32'd0;
                            gi_next     = 32'd0;
                            gd_next     = 32'd0;
                        end
                        CMD_SAMPLE:
                        begin
                            tick_next = tick_reg + TICK_MS;
                            if (active_reg)
                            begin
                                if (at_limit)
                                begin
                                    code_next = ST_UNRES;
                                end
                                else
                                begin
                                    if (over)
                                    begin
                                        drive_next = 8'd0;
                                        if (!seen_reg)
                                        begin
                                            seen_next = 1'b1;
                                            amax_next = q_item.sample;
                                            amin_next = q_item.sample;
                                        end
                                    end
                                    else if (under)
                                    begin
                                        drive_next = cfg.drive_step;
                                    end
                                    if (seen_new && fill_short)
                                    begin
                                        hist_we   = 1'b1;
                                        hist_wd   = q_item.sample;
                                        wp_next   = wp_reg + HIST_AW'(1);
                                        fill_next = fill_reg + 9'd1;
                                    end
                                    cnt_next   = 9'd0;
                                    ismax_next = 1'b1;
                                    ismin_next = 1'b1;
                                end
                            end
                        end
                        CMD_ABORT:
                        begin
                            if (active_reg)
                            begin
                                active_next = 1'b0;
                                drive_next  = 8'd0;
                                status_next = ST_IDLE;
                                gp_next     = 32'd0;
                                gi_next     = 32'd0;
                                gd_next     = 32'd0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                if (scan_issue)
                begin
                    rdp_next = 1'b1;
                    cnt_next = cnt_reg + 9'd1;
                end
                if (rdp_reg)
                begin
                    ismax_next = ismax_reg && (samp_reg > hist_rd);
                    ismin_next = ismin_reg && (samp_reg < hist_rd);
                end
            end
            B_PEAK:
            begin
                hist_we = 1'b1;
                wp_next = wp_reg + HIST_AW'(1);
                if (ismax_reg)
                begin
                    if (samp_reg > amax_reg)
                    begin
                        amax_next = samp_reg;
                    end
                    if (pdir_reg == 2'd0 || pdir_reg == 2'd2)
                    begin
                        pdir_next = 2'd1;
                    end
                    if (pdir_reg == 2'd2)
                    begin
                        pmax_next = lmax_reg;
                    end
                    lmax_next = tick_reg;
                    pk_we     = 1'b1;
                end
                else if (ismin_reg)
                begin
                    if (samp_reg < amin_reg)
                    begin
                        amin_next = samp_reg;
                    end
                    if (pdir_reg == 2'd0 || pdir_reg == 2'd1)
                    begin
                        pdir_next = 2'd2;
                    end
                    pidx_next = pk_pidx;
                    pk_wa     = pk_pidx[PEAK_AW-1:0];
                    pk_we     = (pk_pidx < cyc_eff);
                end
            end
            B_PK1:
            begin
                pk_ra = PEAK_AW'(pidx_reg - 7'd1);
            end
            B_PK2:
            begin
                pk_ra   = PEAK_AW'(pidx_reg - 7'd2);
                p1_next = peak_rd;
            end
            B_PK3:
            begin
                pk_ra   = PEAK_AW'(pidx_reg - 7'd3);
                p2_next = peak_rd;
            end
            B_PK4:
            begin
                p3_next = peak_rd;
            end
            B_CHK:
            begin
                code_next = ST_STABLE;
            end
            B_FIN:
            begin
                d1_next  = K_PI * amp;
                per_next = lmax_reg - pmax_reg;
                sd_next  = K_GD * cfg.drive_step;
            end
            B_MUL1:
            begin
                lo_next = d1_reg[17:0] * per_reg;
            end
            B_MUL2:
            begin
                hi_next = d1_reg[35:18] * per_reg;
            end
            B_MUL3:
            begin
                numd_next = sd_reg * per_reg;
            end
            B_MUL4:
            begin
                dp_next = {hi_reg, 18'd0} + {18'd0, lo_reg};
            end
            B_DIVP:
            begin
                div_start = 1'b1;
            end
            B_WAITP:
            begin
                if (div_done)
                begin
                    gp_next = div_quot;
                end
            end
            B_DIVI:
            begin
                div_num = {8'd0, num_i};
                div_den = dp_reg[DIV_DEN_W-1:0];
                if (d1_reg == 36'd0 || per_reg == 32'd0)
                begin
                    gi_next = (cfg.drive_step != 8'd0) ? SAT32 : 32'd0;
                end
                else if (dp_reg > GI_LIMIT)
                begin
                    gi_next = 32'd0;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            B_WAITI:
            begin
                if (div_done)
                begin
                    gi_next = div_quot;
                end
            end
            B_DIVD:
            begin
                div_num   = numd_reg;
                div_start = 1'b1;
            end
            B_WAITD:
            begin
                if (div_done)
                begin
                    gd_next = div_quot;
                end
            end
            B_DONE:
            begin
                drive_next  = 8'd0;
                active_next = 1'b0;
                status_next = code_reg;
            end
            B_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next       = 1'b1;
                    res_next.heater_drive = drive_reg;
                    res_next.status       = status_reg;
                    res_next.peak_count   = pidx_reg;
                    res_next.gain_p       = status_reg[1] ? gp_reg : 32'd0;
                    res_next.gain_i       = status_reg[1] ? gi_reg : 32'd0;
                    res_next.gain_d       = status_reg[1] ? gd_reg : 32'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= 9'd0;
            wp_reg        <= '0;
            pidx_reg      <= 7'd0;
            pdir_reg      <= 2'd0;
            seen_reg      <= 1'b0;
            amax_reg      <= '0;
            amin_reg      <= '0;
            tick_reg      <= 32'd0;
            lmax_reg      <= 32'd0;
            pmax_reg      <= 32'd0;
            drive_reg     <= 8'd0;
            active_reg    <= 1'b0;
            status_reg    <= ST_IDLE;
            gp_reg        <= 32'd0;
            gi_reg        <= 32'd0;
            gd_reg        <= 32'd0;
            code_reg      <= ST_IDLE;
            cnt_reg       <= 9'd0;
            rdp_reg       <= 1'b0;
            ismax_reg     <= 1'b0;
            ismin_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            pidx_reg      <= pidx_next;
            pdir_reg      <= pdir_next;
            seen_reg      <= seen_next;
            amax_reg      <= amax_next;
            amin_reg      <= amin_next;
            tick_reg      <= tick_next;
            lmax_reg      <= lmax_next;
            pmax_reg      <= pmax_next;
            drive_reg     <= drive_next;
            active_reg    <= active_next;
            status_reg    <= status_next;
            gp_reg        <= gp_next;
            gi_reg        <= gi_next;
            gd_reg        <= gd_next;
            code_reg      <= code_next;
            cnt_reg       <= cnt_next;
            rdp_reg       <= rdp_next;
            ismax_reg     <= ismax_next;
            ismin_reg     <= ismin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        p3_reg   <= p3_next;
        d1_reg   <= d1_next;
        per_reg  <= per_next;
        sd_reg   <= sd_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        numd_reg <= numd_next;
        dp_reg   <= dp_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wp_reg] <= hist_wd;
        end
        hist_rd <= hist_mem[hist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pk_we)
        begin
            peak_mem[pk_wa] <= samp_reg;
        end
        peak_rd <= peak_mem[pk_ra];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the relay PID autotuner: directed and random requests.
// Relay oscillations with random shape drive complete tunes through six
// register settings, extremes among them. A bit-accurate predictor inside
// the scoreboard checks every response field by field. Both ends of the
// stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rpa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    class tune_scoreboard;
        int          tgt;
        int unsigned band, step, cyc_reg, win_reg;
        int          hist[0:WINDOW_DEPTH];
        int          pk[0:MAX_PEAKS-1];
        int unsigned fill, pidx, pdir;
        bit          jchg, overshoot, running;
        int          amax, amin;
        bit [31:0]   ticks, tmax_last, tmax_prev, gp, gi, gd;
        bit [7:0]    drive;
        bit [1:0]    stat;
        result_t     pending_q[$];
        int          errors, stable_tunes, unres_tunes, responses;

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_TARGET: tgt = $signed(v);
                REG_BAND:   band = v[11:0];
                REG_STEP:   step = v[7:0];
                REG_CYCLES: cyc_reg = v[6:0];
                REG_WINDOW: win_reg = v[8:0];
                default: ;
            endcase
        endfunction

        function void clear_tune();
            foreach (hist[i]) hist[i] = 0;
            foreach (pk[i]) pk[i] = 0;
            fill = 0; pidx = 0; pdir = 0;
            jchg = 0; overshoot = 0; running = 0;
            amax = 0; amin = 0;
            ticks = 0; tmax_last = 0; tmax_prev = 0;
            drive = 0; stat = ST_IDLE; gp = 0; gi = 0; gd = 0;
        endfunction

        function new();
            tgt = 2400; band = 8; step = 255; cyc_reg = 8; win_reg = 200;
            errors = 0; stable_tunes = 0; unres_tunes = 0; responses = 0;
            clear_tune();
        endfunction

        function bit [31:0] q16(bit [63:0] num, bit [63:0] den);
            bit [63:0] q, r, frac, res;
            if (den == 0)
                return (num != 0) ? SAT32 : 32'd0;
            q = num / den;
            r = num % den;
            if (q >= 64'd65536)
                return SAT32;
            frac = (r * 64'd131072 + den) / (64'd2 * den);
            res = (q << 16) + frac;
            return (res > 64'hFFFF_FFFF) ? SAT32 : res[31:0];
        endfunction

        function void solve_gains(bit [1:0] code);
            bit [63:0] amp, per, d1, st;
            amp = 64'(longint'(amax) - longint'(amin));
            per = 64'(tmax_last - tmax_prev);
            d1 = 64'd314159 * amp;
            st = step;
            gp = q16(64'd7680000 * st, d1);
            if (d1 == 0 || per == 0)
                gi = (st != 0) ? SAT32 : 32'd0;
            else if (per > (64'd1 << 62) / d1)
                gi = 0;
            else
                gi = q16(64'd15360000000 * st, d1 * per);
            gd = q16(64'd960 * st * per, d1);
            drive = 0;
            running = 0;
            stat = code;
            if (code == ST_STABLE) stable_tunes++;
            else unres_tunes++;
        endfunction

        function void tune_sample(int t);
            int unsigned cyc, wl;
            int          lo, hi, v;
            bit          is_max, is_min;
            longint      a, b, amp;
            cyc = cyc_reg; wl = win_reg;
            lo = tgt - int'(band);
            hi = tgt + int'(band);
            is_max = 1; is_min = 1;
            if (cyc < 8) cyc = 8;
            if (cyc > MAX_PEAKS) cyc = MAX_PEAKS;
            if (wl == 0) wl = 1;
            if (wl > WINDOW_DEPTH) wl = WINDOW_DEPTH;
            if (pidx >= cyc)
            begin
                solve_gains(ST_UNRES);
                return;
            end
            if (t > hi)
            begin
                drive = 0;
                if (!overshoot)
                begin
                    overshoot = 1; amax = t; amin = t;
                end
            end
            else if (t < lo)
                drive = step[7:0];
            if (!overshoot) return;
            for (int i = int'(wl) - 1; i >= 0; i--)
            begin
                v = hist[i];
                if (is_max) is_max = t > v;
                if (is_min) is_min = t < v;
                hist[i + 1] = v;
            end
            hist[0] = t;
            if (fill < wl)
            begin
                fill++;
                return;
            end
            if (is_max)
            begin
                if (t > amax) amax = t;
                if (pdir == 0) pdir = 1;
                if (pdir == 2)
                begin
                    pdir = 1; jchg = 1; tmax_prev = tmax_last;
                end
                tmax_last = ticks;
                if (pidx < MAX_PEAKS) pk[pidx] = t;
            end
            else if (is_min)
            begin
                if (t < amin) amin = t;
                if (pdir == 0) pdir = 2;
                if (pdir == 1)
                begin
                    pdir = 2; pidx++; jchg = 1;
                end
                if (pidx < cyc && pidx < MAX_PEAKS) pk[pidx] = t;
            end
            if (jchg && pidx >= 4 && pidx <= MAX_PEAKS)
            begin
                a = longint'(pk[pidx - 1]) - pk[pidx - 2];
                b = longint'(pk[pidx - 2]) - pk[pidx - 3];
                amp = longint'(amax) - amin;
                if (a < 0) a = -a;
                if (b < 0) b = -b;
                if (10 * (a + b) < amp)
                begin
                    solve_gains(ST_STABLE);
                    return;
                end
            end
            jchg = 0;
        endfunction

        function void note_request(logic [1:0] kind, logic [15:0] smp);
            result_t r;
            if (kind == KIND_START)
            begin
                clear_tune();
                running = 1;
                stat = ST_TUNING;
            end
            else if (kind == KIND_SAMPLE)
            begin
                ticks += TICK_MS;
                if (running) tune_sample($signed(smp));
            end
            else if (kind == KIND_ABORT && running)
            begin
                running = 0; drive = 0;
                stat = ST_IDLE; gp = 0; gi = 0; gd = 0;
            end
            r.heater_drive = drive;
            r.status = stat;
            r.peak_count = pidx[6:0];
            r.gain_p = (stat >= ST_STABLE) ? gp : 32'd0;
            r.gain_i = (stat >= ST_STABLE) ? gi : 32'd0;
            r.gain_d = (stat >= ST_STABLE) ? gd : 32'd0;
            pending_q.push_back(r);
        endfunction

        function void check_response(logic [111:0] data, logic [1:0] user);
            result_t e;
            responses++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: response with no request pending: tdata=%h status=%0d",
                         $time, data, user);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (data[7:0] !== e.heater_drive)
            begin
                $display("%0t: heater_drive expected %0d actual %0d",
                         $time, e.heater_drive, data[7:0]);
                errors++;
            end
            if (user !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, user);
                errors++;
            end
            if (data[14:8] !== e.peak_count)
            begin
                $display("%0t: peak_count expected %0d actual %0d",
                         $time, e.peak_count, data[14:8]);
                errors++;
            end
            if (data[46:15] !== e.gain_p)
            begin
                $display("%0t: gain_p expected %h actual %h", $time, e.gain_p, data[46:15]);
                errors++;
            end
            if (data[78:47] !== e.gain_i)
            begin
                $display("%0t: gain_i expected %h actual %h", $time, e.gain_i, data[78:47]);
                errors++;
            end
            if (data[110:79] !== e.gain_d)
            begin
                $display("%0t: gain_d expected %h actual %h",
                         $time, e.gain_d, data[110:79]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    tune_scoreboard sb = new();
    int send_idle, recv_idle, hold_cycles, stall_count, sent;

    relay_pid_autotuner_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_response(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count == STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("** relay_pid_autotuner_unit: FAILED **");
            $finish;
        end
    end

    task automatic push(input logic [1:0] kind, input logic [15:0] smp);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= smp;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_q.size() != 0);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        sb.write_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int tgt, input int band, input int step,
                             input int cyc, input int win);
        write_reg(REG_TARGET, 16'(tgt));
        write_reg(REG_BAND, 16'(band));
        write_reg(REG_STEP, 16'(step));
        write_reg(REG_CYCLES, 16'(cyc));
        write_reg(REG_WINDOW, 16'(win));
        @(posedge clk);
    endtask

    // one tune: a relay-like triangle oscillation around the setpoint
    task automatic run_tune(input int room);
        int amp, period, half, ph, pos, len, noise, v;
        amp = int'(sb.band) + $urandom_range(5, 300);
        half = $urandom_range(int'(sb.win_reg > 16 ? 16 : sb.win_reg) + 2, 30);
        period = 2 * half;
        ph = $urandom_range(period - 1);
        len = $urandom_range(30, 200);
        if (len > room) len = room;
        if (len < 1) len = 1;
        noise = ($urandom_range(3) == 0) ? amp / 4 + 1 : 1;
        push(KIND_START, 16'($urandom));
        for (int n = 0; n < len; n++)
        begin
            pos = (ph < half) ? ph : period - ph;
            v = sb.tgt - amp + (2 * amp * pos) / half
                + int'($urandom_range(2 * noise)) - noise;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            case ($urandom_range(99))
                0: push(KIND_ABORT, 16'($urandom));
                1: push(2'(CMD_NOP), 16'($urandom));
                2, 3, 4: push(KIND_SAMPLE, 16'($urandom));
                default: push(KIND_SAMPLE, 16'(v));
            endcase
            ph = (ph + 1) % period;
        end
        repeat ($urandom_range(0, 3)) push(KIND_SAMPLE, 16'($urandom));
    endtask

    task automatic run_phase(input int p, input int quota);
        int stop_at;
        stop_at = sent + quota;
        case (p)
            0: configure($urandom_range(0, 4000) - 2000, $urandom_range(0, 30), 255, 8, 4);
            1: configure(-32768, 4095, 0, 0, 0);
            2: configure($urandom_range(0, 4000) - 2000, 0, $urandom_range(255), 127, 1);
            3: configure($urandom_range(0, 4000) - 2000, $urandom_range(0, 40),
                         $urandom_range(255), 64, 300);
            4: configure(0, $urandom_range(0, 4095), 128, $urandom_range(8, 20),
                         $urandom_range(2, 10));
            default: configure(32767, $urandom_range(0, 60), 255, 8, 511);
        endcase
        while (sent < stop_at)
        begin
            if (p == 4 && hold_cycles == 0 && sent > stop_at - quota / 2 && sent < stop_at - 20)
            begin
                hold_cycles = 400;
                repeat (30) push(KIND_SAMPLE, 16'($urandom));
            end
            if (p == 3 && quota > 60) stop_at = sent;
            run_tune(stop_at - sent);
            if (p == 2 && $urandom_range(3) == 0)
            begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (sb.pending_q.size() != 0);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 0;
        stall_count = 0;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push(KIND_SAMPLE, 16'h1234);
        push(KIND_ABORT, 16'h0000);
        push(2'(CMD_NOP), 16'hFFFF);
        push(KIND_START, 16'h0000);
        push(KIND_SAMPLE, 16'h8000);
        push(KIND_SAMPLE, 16'd2380);
        push(KIND_SAMPLE, 16'd2400);
        push(KIND_SAMPLE, 16'h7FFF);
        push(KIND_SAMPLE, 16'h0000);
        push(2'(CMD_NOP), 16'h5555);
        push(KIND_ABORT, 16'hAAAA);
        push(KIND_SAMPLE, 16'd2500);
        push(KIND_START, 16'hFFFF);
        push(KIND_SAMPLE, 16'd2500);
        push(KIND_START, 16'h0001);
        push(KIND_SAMPLE, 16'h8000);
        push(KIND_SAMPLE, 16'd2409);
        push(KIND_SAMPLE, 16'd2391);
        push(KIND_SAMPLE, 16'hFFFF);
        push(KIND_ABORT, 16'h0000);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            send_idle = (p < 2) ? 22 : (p < 4) ? 57 : 0;
            recv_idle = (p < 2) ? 57 : (p < 4) ? 22 : 0;
            run_phase(p, (p == 3) ? 60 : 330);
        end

        $display("Sent %0d requests, checked %0d responses over six register settings.",
                 sent, sb.responses);
        $display("Tunes ended stabilized: %0d, unresolved: %0d.",
                 sb.stable_tunes, sb.unres_tunes);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("** relay_pid_autotuner_unit: PASSED **");
        else
            $display("** relay_pid_autotuner_unit: FAILED **");
        $finish;
    end
endmodule
